// ===== rtl/signed_radix_to_text_formatter_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the radix-to-text formatter checker.
// Each macro expects signals named clk and rst_n in the scope of its use.
// ----------------------------------------------------------------------------
`ifndef SIGNED_RADIX_TO_TEXT_FORMATTER_DEFINES_SVH
`define SIGNED_RADIX_TO_TEXT_FORMATTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRTF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srtf checker: same-cycle rule violated");

// Next-cycle implication, checked outside reset.
`define SRTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srtf checker: next-cycle rule violated");

`endif

// ===== rtl/srtf_pkg.sv =====
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types, constants and helpers of the radix-to-text formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package srtf_pkg;

  // Default parameter values
  localparam int DEF_MAX_RADIX  = 16;
  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_MAX_CHARS  = 64;

  // Fixed field widths
  localparam int RADIX_W = 5;
  localparam int COUNT_W = 6;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;
  localparam int CFG_W   = 64;
  localparam int ADDR_W  = 4;

  // Quotient bits resolved per divider cycle
  localparam int STEP_BITS = 4;

  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  // Register index (paddr bit 3)
  localparam logic REG_CHARS_LOW  = 1'b0;
  localparam logic REG_CHARS_HIGH = 1'b1;

  localparam logic [CFG_W-1:0] CHARS_LOW_RST  = 64'h3736353433323130;
  localparam logic [CFG_W-1:0] CHARS_HIGH_RST = 64'h6665646362613938;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_PREP,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    CLS_SPACE,
    CLS_MINUS,
    CLS_ZERO,
    CLS_DIGIT
  } char_cls_t;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [CFG_W-1:0]   lo,
                                                   input logic [CFG_W-1:0]   hi,
                                                   input logic [DIGIT_W-1:0] d);
    logic [2*CFG_W-1:0] tab;
    tab = {hi, lo};
    return tab[{d, 3'b000} +: CHAR_W];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/signed_radix_to_text_formatter.sv =====
// ----------------------------------------------------------------------------
// signed_radix_to_text_formatter
// Formats a signed integer as text in a radix of 2 to MAX_RADIX: optional
// space padding, a '-' for negative values, '0' padding up to the minimum
// digit count, then the digits from the configured character table, one
// character per result strobe, most significant first. A transaction is
// accepted when start is high and busy is low; the results follow on
// out_strobe one per cycle with no gaps and cannot be held off. A radix
// below two gives one result with out_bad_radix set, in the next cycle.
// Otherwise the item is taken, then each digit takes a divider load, the
// divider iterations and a write-back of the digit into the one-read
// digit memory through the single shared divider; then the length
// arithmetic runs and each character passes the memory read stage and the
// output register. busy stays high until the final character has left the
// read stage.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_radix_to_text_formatter
  import srtf_pkg::*;
#(
  parameter int MAX_RADIX  = DEF_MAX_RADIX,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_CHARS  = DEF_MAX_CHARS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // command channel
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  input  wire logic [RADIX_W-1:0]           in_radix,
  input  wire logic [COUNT_W-1:0]           in_min_digits,
  input  wire logic [COUNT_W-1:0]           in_field_width,
  // result channel
  output      logic                         out_strobe,
  output      logic [CHAR_W-1:0]            out_text_char,
  output      logic                         out_last_char,
  output      logic                         out_bad_radix,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ADDR_W-1:0]            paddr,
  input  wire logic [CFG_W-1:0]             pwdata,
  output      logic [CFG_W-1:0]             prdata,
  output      logic                         pready
);

  // Longest text before truncation: sign plus the wider of the digit
  // padding and the digit count, or the field width.
  localparam int MAX_DIGS = (VALUE_BITS > 63) ? VALUE_BITS : 63;
  localparam int LEN_W    = $clog2(MAX_DIGS + 2);
  localparam int N_W      = $clog2(VALUE_BITS + 1);
  localparam int MEM_AW   = $clog2(VALUE_BITS);

  // --------------------------------------------------------------------------
  // Configuration registers: the digit character table.
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] chars_lo_r;
  logic [CFG_W-1:0] chars_hi_r;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_lo_r <= CHARS_LOW_RST;
      chars_hi_r <= CHARS_HIGH_RST;
    end else if (cfg_we) begin
      // bits below 3 are not decoded, so the two registers alias upwards
      unique case (paddr[3])
        REG_CHARS_LOW:  chars_lo_r <= pwdata;
        REG_CHARS_HIGH: chars_hi_r <= pwdata;
        default:        chars_lo_r <= chars_lo_r;
      endcase
    end
  end

  assign prdata = (paddr[3] == REG_CHARS_HIGH) ? chars_hi_r : chars_lo_r;

  // --------------------------------------------------------------------------
  // Item registers
  // --------------------------------------------------------------------------
  state_t                 state_r, state_nxt;
  logic [VALUE_BITS-1:0]  mag_r;
  logic                   neg_r;
  logic [RADIX_W-1:0]     radix_r;
  logic [COUNT_W-1:0]     prec_r;
  logic [COUNT_W-1:0]     spac_r;
  logic [N_W-1:0]         n_r;
  logic [LEN_W-1:0]       spaces_r;
  logic [LEN_W-1:0]       total_r;
  logic [LEN_W-1:0]       zero_end_r;
  logic [LEN_W-1:0]       emit_cnt_r;
  logic [LEN_W-1:0]       pos_r;

  // read stage of the emit pipe
  logic                   a_vld_r;
  char_cls_t              a_cls_r;
  logic                   a_last_r;
  logic [DIGIT_W-1:0]     rd_data_r;

  // output register
  logic                   out_strobe_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_last_r;
  logic                   out_bad_r;

  // --------------------------------------------------------------------------
  // Accept decode
  // --------------------------------------------------------------------------
  logic                   accept;
  logic                   in_bad;
  logic                   in_neg;
  logic [VALUE_BITS-1:0]  in_mag;

  // hold off new transactions until the last character leaves the read stage
  assign busy   = (state_r != ST_IDLE) | a_vld_r;
  assign accept = start & ~busy;
  assign in_bad = (in_radix < MIN_RADIX);
  assign in_neg = in_value[VALUE_BITS-1];
  // the most negative value wraps to its own unsigned magnitude
  assign in_mag = in_neg ? (~in_value + 1'b1) : in_value;

  // --------------------------------------------------------------------------
  // Shared divider
  // --------------------------------------------------------------------------
  logic                   div_start;
  logic [VALUE_BITS-1:0]  div_quotient;
  div_status_t            div_status;

  srtf_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_r),
    .divisor  (radix_r),
    .quotient (div_quotient),
    .status   (div_status)
  );

  // --------------------------------------------------------------------------
  // Length arithmetic (PREP): total is the wider of the field width and the
  // signed, zero-padded digit string.
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0] pad_len;
  logic [LEN_W-1:0] body_len;
  logic [LEN_W-1:0] total_len;

  assign pad_len   = (LEN_W'(prec_r) > LEN_W'(n_r)) ? LEN_W'(prec_r) : LEN_W'(n_r);
  assign body_len  = pad_len + LEN_W'(neg_r);
  assign total_len = (LEN_W'(spac_r) > body_len) ? LEN_W'(spac_r) : body_len;

  // --------------------------------------------------------------------------
  // Character class at the emit position
  // --------------------------------------------------------------------------
  char_cls_t             emit_cls;
  logic                  emit_last;
  logic [LEN_W-1:0]      digit_idx;
  logic [MEM_AW-1:0]     rd_addr;

  always_comb begin
    if (pos_r < spaces_r) begin
      emit_cls = CLS_SPACE;
    end else if (neg_r && (pos_r == spaces_r)) begin
      emit_cls = CLS_MINUS;
    end else if (pos_r < zero_end_r) begin
      emit_cls = CLS_ZERO;
    end else begin
      emit_cls = CLS_DIGIT;
    end
  end

  // digits sit least significant first, so the final character is entry 0
  assign digit_idx = total_r - 1'b1 - pos_r;
  assign rd_addr   = digit_idx[MEM_AW-1:0];
  assign emit_last = (pos_r == emit_cnt_r - 1'b1);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !in_bad) begin
          state_nxt = (in_mag == '0) ? ST_PREP : ST_LOAD;
        end
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_nxt = (div_quotient == '0) ? ST_PREP : ST_LOAD;
        end
      end
      ST_PREP: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      a_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_vld_r <= (state_r == ST_EMIT);
    end
  end

  // Item datapath: latch the operands, advance the digit count, then fix the
  // text boundaries once all digits are known.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r <= '0;
      n_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept && !in_bad) begin
            mag_r <= in_mag;
            n_r   <= '0;
          end
        end
        ST_DIV: begin
          if (div_status.done) begin
            mag_r <= div_quotient;
            n_r   <= n_r + 1'b1;
          end
        end
        default: begin
          mag_r <= mag_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept && !in_bad) begin
      neg_r   <= in_neg;
      // saturate an over-range radix
      radix_r <= (in_radix > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX) : in_radix;
      // a minimum of zero digits still prints one
      prec_r  <= (in_min_digits == '0) ? COUNT_W'(1) : in_min_digits;
      spac_r  <= in_field_width;
    end
    if (state_r == ST_PREP) begin
      total_r    <= total_len;
      spaces_r   <= total_len - body_len;
      zero_end_r <= total_len - LEN_W'(n_r);
      emit_cnt_r <= (total_len > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : total_len;
      pos_r      <= '0;
    end else if (state_r == ST_EMIT) begin
      pos_r <= pos_r + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Digit memory: one write port from the divider, one registered read port
  // for the emit pipe.
  // --------------------------------------------------------------------------
  logic [DIGIT_W-1:0] digit_mem [VALUE_BITS];

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && div_status.done) begin
      digit_mem[n_r[MEM_AW-1:0]] <= div_status.rem;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= digit_mem[rd_addr];
    a_cls_r   <= emit_cls;
    a_last_r  <= emit_last;
  end

  // --------------------------------------------------------------------------
  // Output register: the error result or the next character.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (accept & in_bad) | a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_bad) begin
      out_char_r <= CHAR_NONE;
      out_last_r <= 1'b1;
      out_bad_r  <= 1'b1;
    end else begin
      case (a_cls_r)
        CLS_SPACE: out_char_r <= CHAR_SPACE;
        CLS_MINUS: out_char_r <= CHAR_MINUS;
        CLS_ZERO:  out_char_r <= CHAR_ZERO;
        default:   out_char_r <= digit_char(chars_lo_r, chars_hi_r, rd_data_r);
      endcase
      out_last_r <= a_last_r;
      out_bad_r  <= 1'b0;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;
  assign out_bad_radix = out_bad_r;

endmodule

`default_nettype wire

// ===== rtl/srtf_divider.sv =====
// ----------------------------------------------------------------------------
// srtf_divider
// Iterative divider by a small radix, STEP_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_divider
  import srtf_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [RADIX_W-1:0]    divisor,
  output      logic [VALUE_BITS-1:0] quotient,
  output      div_status_t           status
);

  localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W = STEPS * STEP_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DIV_W-1:0]   w_r, w_nxt;
  logic [DIGIT_W-1:0] r_r, r_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               done_r;

  // Restoring steps: shift the top dividend bit into the remainder, subtract
  // where it fits and shift the quotient bit in at the bottom.
  always_comb begin
    logic [RADIX_W-1:0] r;
    logic [DIV_W-1:0]   w;
    r = {1'b0, r_r};
    w = w_r;
    for (int k = 0; k < STEP_BITS; k++) begin
      r = {r[DIGIT_W-1:0], w[DIV_W-1]};
      w = {w[DIV_W-2:0], 1'b0};
      if (r >= divisor) begin
        r    = r - divisor;
        w[0] = 1'b1;
      end
    end
    w_nxt = w;
    r_nxt = r[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(STEPS);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w_r <= DIV_W'(dividend);
      r_r <= '0;
    end else if (cnt_r != '0) begin
      w_r <= w_nxt;
      r_r <= r_nxt;
    end
  end

  assign quotient    = w_r[VALUE_BITS-1:0];
  assign status.done = done_r;
  assign status.rem  = r_r;

endmodule

`default_nettype wire

// ===== rtl/srtf_checker.sv =====
// ----------------------------------------------------------------------------
// srtf_checker
// Port-level checks of the radix-to-text formatter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_radix_to_text_formatter_defines.svh"

module srtf_checker
  import srtf_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic [RADIX_W-1:0] in_radix,
  input wire logic               out_strobe,
  input wire logic [CHAR_W-1:0]  out_text_char,
  input wire logic               out_last_char,
  input wire logic               out_bad_radix
);

  // an error transaction answers with a single marked result
  `SRTF_ASSERT_NEXT(a_bad_answers, start && !busy && (in_radix < MIN_RADIX), out_strobe && out_bad_radix)
  `SRTF_ASSERT_NOW(a_bad_single, out_strobe && out_bad_radix, out_last_char && (out_text_char == CHAR_NONE))
  // a good transaction makes the block busy
  `SRTF_ASSERT_NEXT(a_good_busy, start && !busy && (in_radix >= MIN_RADIX), busy)
  // characters of one text come back to back
  `SRTF_ASSERT_NEXT(a_no_gaps, out_strobe && !out_last_char, out_strobe)
  // the final character frees the block
  `SRTF_ASSERT_NOW(a_last_frees, out_strobe && out_last_char && !out_bad_radix, !busy)

endmodule

bind signed_radix_to_text_formatter srtf_checker u_srtf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_radix      (in_radix),
  .out_strobe    (out_strobe),
  .out_text_char (out_text_char),
  .out_last_char (out_last_char),
  .out_bad_radix (out_bad_radix)
);

`default_nettype wire
